/* rtl/core/qafs_pkg.sv */
// shared types and constants for the quote aware field splitter
// no dependencies
package qafs_pkg;

   localparam int CHAR_W       = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 8;
   localparam int COUNT_W      = 3;
   localparam int MAX_RESULTS  = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CHAR_W-1:0] CH_DQ = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQ = 8'h27;
   localparam logic [CHAR_W-1:0] CH_BS = 8'h5c;

   localparam logic [COUNT_W-1:0] MAX_DELIMS = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_A     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_B     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_C     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_D     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_COUNT = 3'd4;

   localparam logic [CHAR_W-1:0]  DELIM_A_RESET     = 8'd32;
   localparam logic [CHAR_W-1:0]  DELIM_B_RESET     = 8'd44;
   localparam logic [CHAR_W-1:0]  DELIM_C_RESET     = 8'd9;
   localparam logic [CHAR_W-1:0]  DELIM_D_RESET     = 8'd59;
   localparam logic [COUNT_W-1:0] DELIM_COUNT_RESET = 3'd1;

   typedef enum logic [1:0] {
      KIND_CHAR      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_STATUS    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_DOUBLE = 2'd1,
      QUOTE_SINGLE = 2'd2
   } quote_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  delim_a;
      logic [CHAR_W-1:0]  delim_b;
      logic [CHAR_W-1:0]  delim_c;
      logic [CHAR_W-1:0]  delim_d;
      logic [COUNT_W-1:0] delim_count;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] ch;
      logic              uq;
   } result_type;

   typedef struct packed {
      logic [MAX_RESULTS-1:0]                mask;
      result_type [MAX_RESULTS-1:0]          res;
   } bundle_type;

endpackage

/* rtl/core/qafs_req_if.sv */
// input channel of the field splitter: one character beat
// depends on qafs_pkg
interface qafs_req_if;
   logic                        valid;
   logic                        ready;
   logic [qafs_pkg::CHAR_W-1:0] ch;
   logic                        has_char;
   logic                        final_item;

   modport source (output valid, ch, has_char, final_item, input ready);
   modport sink   (input valid, ch, has_char, final_item, output ready);
endinterface

/* rtl/core/qafs_rsp_if.sv */
// result channel of the field splitter: one result beat
// depends on qafs_pkg
interface qafs_rsp_if;
   logic                        valid;
   logic                        ready;
   qafs_pkg::kind_type          kind;
   logic [qafs_pkg::CHAR_W-1:0] out_ch;
   logic                        unmatched_quote;
   logic                        run_last;

   modport source (output valid, kind, out_ch, unmatched_quote, run_last, input ready);
   modport sink   (input valid, kind, out_ch, unmatched_quote, run_last, output ready);
endinterface

/* rtl/core/quote_aware_field_splitter.sv */
// quote aware field splitter, top level with delimiter registers
// depends on qafs_pkg, qafs_req_if, qafs_rsp_if, qafs_front, qafs_queue, qafs_back
//
// usage: one character per req beat (has_char set), final_item marks the end of a
// string; an end-only beat (has_char clear, final_item set) closes a string. each
// rsp beat is a field character, an end of field or an end of string status;
// run_last flags the last result caused by one req beat. beats with no result
// produce nothing. delimiters are written through csr_we/csr_index/csr_wdata
// while the block is idle.
// a beat's results are held in the queue registers and then in the back end's before rsp.
// throughput: one req beat per cycle while the queue is not full; a beat that
// yields k results sends them as k rsp beats, and a queue of QUEUE_DEPTH result
// bundles between the classifier and the result sender absorbs the burst.
// reset: quote, held backslash and field state cleared, delimiters to defaults,
// queue emptied. when rsp stalls the queue fills and req.ready drops once it
// is full; nothing is lost.
module quote_aware_field_splitter #(
   parameter int QUEUE_DEPTH = qafs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   qafs_req_if.sink                        req,
   qafs_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [qafs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qafs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   qafs_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 push_valid;
   qafs_pkg::bundle_type push_data;
   logic                 queue_full;
   logic                 head_valid;
   logic                 pop;
   qafs_pkg::bundle_type head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            qafs_pkg::CSR_DELIM_A:     cfg_in.delim_a = csr_wdata;
            qafs_pkg::CSR_DELIM_B:     cfg_in.delim_b = csr_wdata;
            qafs_pkg::CSR_DELIM_C:     cfg_in.delim_c = csr_wdata;
            qafs_pkg::CSR_DELIM_D:     cfg_in.delim_d = csr_wdata;
            qafs_pkg::CSR_DELIM_COUNT: cfg_in.delim_count = csr_wdata[qafs_pkg::COUNT_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delim_a     <= qafs_pkg::DELIM_A_RESET;
         cfg_ff.delim_b     <= qafs_pkg::DELIM_B_RESET;
         cfg_ff.delim_c     <= qafs_pkg::DELIM_C_RESET;
         cfg_ff.delim_d     <= qafs_pkg::DELIM_D_RESET;
         cfg_ff.delim_count <= qafs_pkg::DELIM_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qafs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   qafs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .not_empty  (head_valid),
      .pop        (pop),
      .head       (head)
   );

   qafs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp)
   );

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_valid && queue_full))
      else $error("bundle pushed into a full queue");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (rsp.kind == qafs_pkg::KIND_STATUS)) |-> rsp.run_last)
      else $error("status result not last of its beat");

   a_uq_only_status: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.unmatched_quote) |-> (rsp.kind == qafs_pkg::KIND_STATUS))
      else $error("unmatched quote flag outside a status result");

   a_no_pop_when_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !pop)
      else $error("bundle taken while a result is stalled");
`endif

endmodule

/* rtl/core/qafs_front.sv */
// front end: takes character beats, tracks quote state, builds result bundles
// depends on qafs_pkg and qafs_req_if
module qafs_front (
   input  logic                 clock,
   input  logic                 reset,
   qafs_req_if.sink             req,
   input  qafs_pkg::cfg_type    cfg,
   input  logic                 queue_full,
   output logic                 push_valid,
   output qafs_pkg::bundle_type push_data
);

   typedef struct packed {
      qafs_pkg::quote_type  oq;
      logic                 hold;
      logic                 fhc;
      logic                 emit;
      qafs_pkg::result_type r;
   } step_type;

   function automatic logic is_delim(logic [qafs_pkg::CHAR_W-1:0] c, qafs_pkg::cfg_type k);
      logic [qafs_pkg::COUNT_W-1:0] n;
      n = (k.delim_count > qafs_pkg::MAX_DELIMS) ? qafs_pkg::MAX_DELIMS : k.delim_count;
      return ((n >= 3'd1) && (c == k.delim_a)) || ((n >= 3'd2) && (c == k.delim_b)) ||
             ((n >= 3'd3) && (c == k.delim_c)) || ((n >= 3'd4) && (c == k.delim_d));
   endfunction

   function automatic logic closes(qafs_pkg::quote_type oq, logic [qafs_pkg::CHAR_W-1:0] c);
      return ((oq == qafs_pkg::QUOTE_DOUBLE) && (c == qafs_pkg::CH_DQ)) ||
             ((oq == qafs_pkg::QUOTE_SINGLE) && (c == qafs_pkg::CH_SQ));
   endfunction

   function automatic step_type handle(qafs_pkg::quote_type oq, logic fhc,
                                       logic [qafs_pkg::CHAR_W-1:0] c, logic can_hold,
                                       qafs_pkg::cfg_type k);
      step_type s;
      s.oq   = oq;
      s.hold = 1'b0;
      s.fhc  = fhc;
      s.emit = 1'b0;
      s.r    = '{kind: qafs_pkg::KIND_CHAR, ch: '0, uq: 1'b0};
      priority if ((oq == qafs_pkg::QUOTE_NONE) &&
                   ((c == qafs_pkg::CH_DQ) || (c == qafs_pkg::CH_SQ))) begin
         s.oq = (c == qafs_pkg::CH_DQ) ? qafs_pkg::QUOTE_DOUBLE : qafs_pkg::QUOTE_SINGLE;
      end else if ((c == qafs_pkg::CH_BS) && can_hold) begin
         s.hold = 1'b1;
      end else if (closes(oq, c)) begin
         s.oq = qafs_pkg::QUOTE_NONE;
      end else if ((oq == qafs_pkg::QUOTE_NONE) && is_delim(c, k)) begin
         if (fhc) begin
            s.emit   = 1'b1;
            s.r.kind = qafs_pkg::KIND_FIELD_END;
            s.fhc    = 1'b0;
         end
      end else begin
         s.emit = 1'b1;
         s.r.ch = c;
         s.fhc  = 1'b1;
      end
      return s;
   endfunction

   qafs_pkg::quote_type oq_ff, oq_in;
   logic                held_ff, held_in;
   logic                fhc_ff, fhc_in;

   logic     accept;
   logic     esc;
   logic     bs_path;
   logic     ch_path;
   step_type h1, h2;
   qafs_pkg::bundle_type b;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      esc = 1'b0;
      if (oq_ff == qafs_pkg::QUOTE_NONE) begin
         esc = (req.ch == qafs_pkg::CH_DQ) || (req.ch == qafs_pkg::CH_SQ);
      end else begin
         esc = closes(oq_ff, req.ch);
      end
      bs_path = held_ff && ((req.has_char && !esc) || (!req.has_char && req.final_item));
      ch_path = req.has_char && !(held_ff && esc);

      h1 = handle(oq_ff, fhc_ff, qafs_pkg::CH_BS, 1'b0, cfg);
      if (bs_path) begin
         h2 = handle(h1.oq, h1.fhc, req.ch, !req.final_item, cfg);
      end else begin
         h2 = handle(oq_ff, fhc_ff, req.ch, !req.final_item, cfg);
      end

      b.mask = '0;
      for (int i = 0; i < qafs_pkg::MAX_RESULTS; i++) begin
         b.res[i] = '{kind: qafs_pkg::KIND_CHAR, ch: '0, uq: 1'b0};
      end
      oq_in   = oq_ff;
      held_in = held_ff;
      fhc_in  = fhc_ff;

      if (req.has_char && held_ff && esc) begin
         b.mask[0]   = 1'b1;
         b.res[0].ch = req.ch;
         fhc_in      = 1'b1;
         held_in     = 1'b0;
      end else if (bs_path) begin
         b.mask[0] = h1.emit;
         b.res[0]  = h1.r;
         oq_in     = h1.oq;
         fhc_in    = h1.fhc;
         held_in   = 1'b0;
      end
      if (ch_path) begin
         b.mask[1] = h2.emit;
         b.res[1]  = h2.r;
         oq_in     = h2.oq;
         fhc_in    = h2.fhc;
         held_in   = h2.hold;
      end

      if (req.final_item) begin
         b.mask[2]      = fhc_in;
         b.res[2].kind  = qafs_pkg::KIND_FIELD_END;
         b.mask[3]      = 1'b1;
         b.res[3].kind  = qafs_pkg::KIND_STATUS;
         b.res[3].uq    = (oq_in != qafs_pkg::QUOTE_NONE);
         oq_in          = qafs_pkg::QUOTE_NONE;
         held_in        = 1'b0;
         fhc_in         = 1'b0;
      end
   end

   assign push_valid = accept && (b.mask != '0);
   assign push_data  = b;

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_ff   <= qafs_pkg::QUOTE_NONE;
         held_ff <= 1'b0;
         fhc_ff  <= 1'b0;
      end else if (accept) begin
         oq_ff   <= oq_in;
         held_ff <= held_in;
         fhc_ff  <= fhc_in;
      end
   end

endmodule

/* rtl/core/qafs_queue.sv */
// short bundle queue between front and back end, register based
// depends on qafs_pkg
module qafs_queue #(
   parameter int DEPTH = qafs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  qafs_pkg::bundle_type push_data,
   output logic                 full,
   output logic                 not_empty,
   input  logic                 pop,
   output qafs_pkg::bundle_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   qafs_pkg::bundle_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == FULL_COUNT);
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/qafs_back.sv */
// back end: holds one bundle and sends its results one beat at a time
// depends on qafs_pkg and qafs_rsp_if
module qafs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  qafs_pkg::bundle_type head,
   output logic                 pop,
   qafs_rsp_if.source           rsp
);

   logic [qafs_pkg::MAX_RESULTS-1:0]     mask_ff, mask_in;
   qafs_pkg::result_type [qafs_pkg::MAX_RESULTS-1:0] res_ff;
   logic [qafs_pkg::MAX_RESULTS-1:0]     sel;
   logic [qafs_pkg::MAX_RESULTS-1:0]     rest;
   qafs_pkg::result_type                 cur;

   always_comb begin
      sel = mask_ff & (~mask_ff + 1'b1);
      cur = '{kind: qafs_pkg::KIND_CHAR, ch: '0, uq: 1'b0};
      for (int i = 0; i < qafs_pkg::MAX_RESULTS; i++) begin
         if (sel[i]) begin
            cur = res_ff[i];
         end
      end
   end

   assign rsp.valid           = (mask_ff != '0);
   assign rsp.kind            = cur.kind;
   assign rsp.out_ch          = cur.ch;
   assign rsp.unmatched_quote = cur.uq;
   assign rsp.run_last        = ((mask_ff & ~sel) == '0);

   assign rest    = (rsp.valid && rsp.ready) ? (mask_ff & ~sel) : mask_ff;
   assign pop     = (rest == '0) && head_valid;
   assign mask_in = pop ? head.mask : rest;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= head.res;
      end
   end

endmodule

/* bench/quote_aware_field_splitter_tb.sv */
// testbench for quote_aware_field_splitter: directed and random text, checked beat by beat
// against a field splitter predictor kept in step with the delimiter registers
// depends on qafs_pkg, qafs_req_if, qafs_rsp_if and the rtl of the block
module quote_aware_field_splitter_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 80;

   typedef struct packed {
      qafs_pkg::kind_type          kind;
      logic [qafs_pkg::CHAR_W-1:0] ch;
      logic                        uq;
      logic                        last;
   } token_beat_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [qafs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [qafs_pkg::CSR_DATA_W-1:0]  csr_wdata;

   qafs_req_if req();
   qafs_rsp_if rsp();

   quote_aware_field_splitter DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // splitter state and delimiter registers as the block should hold them
   logic [qafs_pkg::CHAR_W-1:0]  delim_reg [4];
   logic [qafs_pkg::COUNT_W-1:0] delim_used;
   qafs_pkg::quote_type          quote_state;
   bit                           backslash_held;
   bit                           field_open;

   token_beat_type step_tokens[$];
   token_beat_type token_q[$];

   int error_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_asks;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void emit_token(qafs_pkg::kind_type k, logic [qafs_pkg::CHAR_W-1:0] c,
                                      logic uq);
      token_beat_type t;
      if (step_tokens.size() >= qafs_pkg::MAX_RESULTS)
         return;
      t.kind = k;
      t.ch   = c;
      t.uq   = uq;
      t.last = 1'b0;
      step_tokens = {step_tokens, t};
   endfunction

   function automatic bit is_delimiter(logic [qafs_pkg::CHAR_W-1:0] c);
      int n;
      n = (delim_used > qafs_pkg::MAX_DELIMS) ? int'(qafs_pkg::MAX_DELIMS) : int'(delim_used);
      for (int i = 0; i < n; i++)
         if (c == delim_reg[i])
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [qafs_pkg::CHAR_W-1:0] closing_quote();
      return (quote_state == qafs_pkg::QUOTE_DOUBLE) ? qafs_pkg::CH_DQ : qafs_pkg::CH_SQ;
   endfunction

   function automatic void classify_char(logic [qafs_pkg::CHAR_W-1:0] c, bit can_hold);
      if (quote_state == qafs_pkg::QUOTE_NONE &&
          (c == qafs_pkg::CH_DQ || c == qafs_pkg::CH_SQ)) begin
         if (c == qafs_pkg::CH_DQ)
            quote_state = qafs_pkg::QUOTE_DOUBLE;
         else
            quote_state = qafs_pkg::QUOTE_SINGLE;
         return;
      end
      if (c == qafs_pkg::CH_BS && can_hold) begin
         backslash_held = 1'b1;
         return;
      end
      if (quote_state != qafs_pkg::QUOTE_NONE && c == closing_quote()) begin
         quote_state = qafs_pkg::QUOTE_NONE;
         return;
      end
      if (quote_state == qafs_pkg::QUOTE_NONE && is_delimiter(c)) begin
         if (field_open) begin
            emit_token(qafs_pkg::KIND_FIELD_END, '0, 1'b0);
            field_open = 1'b0;
         end
         return;
      end
      emit_token(qafs_pkg::KIND_CHAR, c, 1'b0);
      field_open = 1'b1;
   endfunction

   function automatic void tokenize_step(logic [qafs_pkg::CHAR_W-1:0] c, bit has, bit fin);
      bit             escaped;
      token_beat_type t;
      step_tokens.delete();
      if (has) begin
         if (backslash_held) begin
            backslash_held = 1'b0;
            if (quote_state == qafs_pkg::QUOTE_NONE)
               escaped = (c == qafs_pkg::CH_DQ || c == qafs_pkg::CH_SQ);
            else
               escaped = (c == closing_quote());
            if (escaped) begin
               emit_token(qafs_pkg::KIND_CHAR, c, 1'b0);
               field_open = 1'b1;
            end else begin
               classify_char(qafs_pkg::CH_BS, 1'b0);
               classify_char(c, !fin);
            end
         end else begin
            classify_char(c, !fin);
         end
      end else if (fin && backslash_held) begin
         backslash_held = 1'b0;
         classify_char(qafs_pkg::CH_BS, 1'b0);
      end
      if (fin) begin
         if (field_open)
            emit_token(qafs_pkg::KIND_FIELD_END, '0, 1'b0);
         emit_token(qafs_pkg::KIND_STATUS, '0, quote_state != qafs_pkg::QUOTE_NONE);
         quote_state    = qafs_pkg::QUOTE_NONE;
         backslash_held = 1'b0;
         field_open     = 1'b0;
      end
      foreach (step_tokens[i]) begin
         t = step_tokens[i];
         t.last = (i == step_tokens.size() - 1);
         token_q = {token_q, t};
      end
   endfunction

   task automatic report_mismatch(string what, logic [qafs_pkg::CHAR_W-1:0] got,
                                  logic [qafs_pkg::CHAR_W-1:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // monitor: predict on every accepted req beat, check every accepted rsp beat
   initial begin
      token_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req.valid && req.ready)
               tokenize_step(req.ch, req.has_char, req.final_item);
            if (rsp.valid && rsp.ready) begin
               if (token_q.size() == 0) begin
                  report_mismatch("unexpected beat, kind", {6'b0, rsp.kind}, '0);
               end else begin
                  want = token_q.pop_front();
                  if (rsp.kind !== want.kind)
                     report_mismatch("kind", {6'b0, rsp.kind}, {6'b0, want.kind});
                  if (rsp.out_ch !== want.ch)
                     report_mismatch("out_ch", rsp.out_ch, want.ch);
                  if (rsp.unmatched_quote !== want.uq)
                     report_mismatch("unmatched_quote", {7'b0, rsp.unmatched_quote},
                                     {7'b0, want.uq});
                  if (rsp.run_last !== want.last)
                     report_mismatch("run_last", {7'b0, rsp.run_last}, {7'b0, want.last});
               end
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off whenever one is asked for
   initial begin
      int stall_left;
      int asks_seen;
      stall_left = 0;
      asks_seen  = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (asks_seen != hold_asks) begin
            asks_seen  = hold_asks;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("** quote_aware_field_splitter: FAILED **");
      $finish;
   end

   task automatic send_beat(logic [qafs_pkg::CHAR_W-1:0] c, bit has, bit fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.ch         <= c;
      req.has_char   <= has;
      req.final_item <= fin;
      @(posedge clock);
      while (!req.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(string s, bit end_only);
      for (int i = 0; i < s.len(); i++)
         send_beat(s[i], 1'b1, !end_only && i == s.len() - 1);
      if (end_only)
         send_beat(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_for_drain();
      req.valid <= 1'b0;
      while (token_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [qafs_pkg::CSR_INDEX_W-1:0] index,
                                 logic [qafs_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         qafs_pkg::CSR_DELIM_A:     delim_reg[0] = data;
         qafs_pkg::CSR_DELIM_B:     delim_reg[1] = data;
         qafs_pkg::CSR_DELIM_C:     delim_reg[2] = data;
         qafs_pkg::CSR_DELIM_D:     delim_reg[3] = data;
         qafs_pkg::CSR_DELIM_COUNT: delim_used   = data[qafs_pkg::COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_delimiters(logic [qafs_pkg::CHAR_W-1:0] a, logic [qafs_pkg::CHAR_W-1:0] b,
                                 logic [qafs_pkg::CHAR_W-1:0] c, logic [qafs_pkg::CHAR_W-1:0] d,
                                 logic [qafs_pkg::COUNT_W-1:0] count);
      wait_for_drain();
      write_register(qafs_pkg::CSR_DELIM_A, a);
      write_register(qafs_pkg::CSR_DELIM_B, b);
      write_register(qafs_pkg::CSR_DELIM_C, c);
      write_register(qafs_pkg::CSR_DELIM_D, d);
      write_register(qafs_pkg::CSR_DELIM_COUNT,
                     {{(qafs_pkg::CSR_DATA_W-qafs_pkg::COUNT_W){1'b0}}, count});
      csr_we <= 1'b0;
   endtask

   function automatic logic [qafs_pkg::CHAR_W-1:0] random_text_char();
      int r;
      r = $urandom_range(99);
      if (r < 40)
         return 8'($urandom_range(97, 122));
      if (r < 58)
         return delim_reg[2'($urandom_range(3))];
      if (r < 68)
         return $urandom_range(1) ? qafs_pkg::CH_DQ : qafs_pkg::CH_SQ;
      if (r < 76)
         return qafs_pkg::CH_BS;
      return 8'($urandom_range(255));
   endfunction

   task automatic test_random_text(int n_items);
      int  sent;
      int  len;
      bit  tail;
      sent = 0;
      while (sent < n_items) begin
         len  = $urandom_range(8);
         tail = (len == 0) || ($urandom_range(3) == 0);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0)
               send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(random_text_char(), 1'b1, !tail && i == len - 1);
            sent++;
         end
         if (tail) begin
            send_beat(8'($urandom), 1'b0, 1'b1);
            sent++;
         end
      end
   endtask

   task automatic test_directed_cases();
      send_text("\"x y\"", 1'b1);
      send_text("\\'q\\z", 1'b0);
      send_text("'a\\\"", 1'b0);
      send_beat(8'hA5, 1'b0, 1'b1);
      send_beat(8'h5A, 1'b0, 1'b0);
      send_beat(" ", 1'b1, 1'b0);
      send_beat(" ", 1'b1, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(" ", 1'b1, 1'b0);
      send_beat(qafs_pkg::CH_BS, 1'b1, 1'b1);
      send_text("\\", 1'b1);
   endtask

   task automatic test_delimiter_sets();
      set_delimiters(",", ";", 8'h09, "|", 3'd4);
      test_random_text(20);
      set_delimiters(qafs_pkg::DELIM_A_RESET, qafs_pkg::DELIM_B_RESET,
                     qafs_pkg::DELIM_C_RESET, qafs_pkg::DELIM_D_RESET, 3'd0);
      test_random_text(15);
      // count above four, extreme bytes, a quote and a backslash as delimiters
      set_delimiters(8'h00, 8'hFF, qafs_pkg::CH_DQ, qafs_pkg::CH_BS, 3'd7);
      send_beat(8'h41, 1'b1, 1'b0);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'h42, 1'b1, 1'b0);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_text("\"c\\d\"e\\f", 1'b1);
      test_random_text(20);
      set_delimiters(qafs_pkg::CH_SQ, " ", qafs_pkg::CH_BS, 8'h80, 3'd3);
      test_random_text(20);
      set_delimiters(qafs_pkg::DELIM_A_RESET, qafs_pkg::DELIM_B_RESET,
                     qafs_pkg::DELIM_C_RESET, qafs_pkg::DELIM_D_RESET, 3'd2);
   endtask

   task automatic test_result_hold_off();
      hold_asks++;
      send_text("ab,cd ef,gh ij kl,mn op qr,st", 1'b0);
      wait_for_drain();
   endtask

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= qafs_pkg::CSR_DELIM_A;
      csr_wdata      <= '0;
      req.valid      <= 1'b0;
      req.ch         <= '0;
      req.has_char   <= 1'b0;
      req.final_item <= 1'b0;
      delim_reg[0]   = qafs_pkg::DELIM_A_RESET;
      delim_reg[1]   = qafs_pkg::DELIM_B_RESET;
      delim_reg[2]   = qafs_pkg::DELIM_C_RESET;
      delim_reg[3]   = qafs_pkg::DELIM_D_RESET;
      delim_used     = qafs_pkg::DELIM_COUNT_RESET;
      quote_state    = qafs_pkg::QUOTE_NONE;
      backslash_held = 1'b0;
      field_open     = 1'b0;
      error_count    = 0;
      hold_asks      = 0;
      send_idle_pct  = 19;
      recv_idle_pct  = 56;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_delimiter_sets();
      send_idle_pct = 56;
      recv_idle_pct = 19;
      test_random_text(45);
      test_result_hold_off();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_delimiters(qafs_pkg::DELIM_A_RESET, qafs_pkg::DELIM_B_RESET,
                     qafs_pkg::DELIM_C_RESET, qafs_pkg::DELIM_D_RESET, 3'd4);
      test_random_text(30);

      wait_for_drain();
      if (error_count == 0)
         $display("** quote_aware_field_splitter: PASSED **");
      else
         $display("** quote_aware_field_splitter: FAILED **");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/qafs_pkg.sv
rtl/core/qafs_req_if.sv
rtl/core/qafs_rsp_if.sv
rtl/core/qafs_front.sv
rtl/core/qafs_queue.sv
rtl/core/qafs_back.sv
rtl/core/quote_aware_field_splitter.sv
bench/quote_aware_field_splitter_tb.sv
